// ===== hw/rtl/lsvc_pkg.sv =====
// Limit-switch valve controller: shared types and constants.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package lsvc_pkg;

   localparam int CMD_W     = 2;
   localparam int TIME_W    = 32;
   localparam int REQ_PCT_W = 8;
   localparam int MODE_W    = 3;
   localparam int PCT_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 32;

   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd3;

   localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_OPENING  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OPENED   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLOSING  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLOSED   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FLOATING = 3'd5;
   localparam logic [MODE_W-1:0] MODE_FAULTED  = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_SWITCH_ABSENT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSIT_TIMEOUT_MS = 1'd1;

   localparam logic [PCT_W-1:0]     FULL_OPEN        = 7'd100;
   localparam logic [REQ_PCT_W-1:0] FULL_OPEN_REQ    = 8'd100;
   localparam logic [TIME_W-1:0]    TIMEOUT_RESET_MS = 32'd5000;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [TIME_W-1:0]    now_ms;
      logic                 open_switch;
      logic                 close_switch;
      logic [REQ_PCT_W-1:0] percent_request;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0] valve_state;
      logic [PCT_W-1:0]  commanded_percent;
      logic              servo_write;
      logic [PCT_W-1:0]  servo_percent;
      logic              moving;
      logic              open_level;
      logic              close_level;
      logic              fault_both;
   } rsp_type;

   typedef struct packed {
      logic              open_switch_absent;
      logic [TIME_W-1:0] transit_timeout_ms;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lsvc_csr.sv =====
// Limit-switch valve controller: configuration registers.
// Depends on lsvc_pkg.
`default_nettype none

module lsvc_csr
   import lsvc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_switch_absent <= 1'b0;
         cfg_ff.transit_timeout_ms <= TIMEOUT_RESET_MS;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OPEN_SWITCH_ABSENT: cfg_ff.open_switch_absent <= csr_data[0];
            CSR_TRANSIT_TIMEOUT_MS: cfg_ff.transit_timeout_ms <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsvc_engine.sv =====
// Limit-switch valve controller: valve state registers and per-item update.
// Depends on lsvc_pkg.
`default_nettype none

module lsvc_engine
   import lsvc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic              moving_ff, moving_in;
   logic              open_seen_ff, open_seen_in;
   logic              close_seen_ff, close_seen_in;
   logic              both_ff, both_in;
   logic [TIME_W-1:0] start_ff, start_in;

   logic [CMD_W-1:0]     cmd;
   logic [REQ_PCT_W-1:0] req_pct;
   logic [PCT_W-1:0]     clamp_pct;
   logic [TIME_W-1:0]    elapsed;
   logic                 timed_out;
   logic                 o_sw;
   logic                 c_sw;
   logic                 wr;
   logic [PCT_W-1:0]     sp;

   always_comb begin
      cmd     = req.cmd;
      req_pct = req.percent_request;
      if (cmd == CMD_OPEN && cfg.open_switch_absent) begin
         cmd     = CMD_SET;
         req_pct = FULL_OPEN_REQ;
      end
      clamp_pct = (req_pct > FULL_OPEN_REQ) ? FULL_OPEN : req_pct[PCT_W-1:0];
      o_sw      = req.open_switch & ~cfg.open_switch_absent;
      c_sw      = req.close_switch;
      elapsed   = req.now_ms - start_ff;
      timed_out = (elapsed >= cfg.transit_timeout_ms);

      mode_in       = mode_ff;
      pct_in        = pct_ff;
      moving_in     = moving_ff;
      open_seen_in  = open_seen_ff;
      close_seen_in = close_seen_ff;
      both_in       = both_ff;
      start_in      = start_ff;
      wr            = 1'b0;
      sp            = '0;

      case (cmd)
         CMD_TICK: begin
            open_seen_in  = o_sw;
            close_seen_in = c_sw;
            if (o_sw && c_sw) begin
               both_in   = 1'b1;
               moving_in = 1'b0;
               mode_in   = MODE_FAULTED;
            end else begin
               both_in = 1'b0;
               case (mode_ff)
                  MODE_OPENING: begin
                     if (o_sw) begin
                        mode_in   = MODE_OPENED;
                        moving_in = 1'b0;
                     end else if (timed_out) begin
                        mode_in   = MODE_FAULTED;
                        moving_in = 1'b0;
                     end
                  end
                  MODE_CLOSING: begin
                     if (c_sw) begin
                        mode_in   = MODE_CLOSED;
                        moving_in = 1'b0;
                     end else if (timed_out) begin
                        mode_in   = MODE_FAULTED;
                        moving_in = 1'b0;
                     end
                  end
                  MODE_OPENED: begin
                     if (!o_sw) mode_in = MODE_FLOATING;
                  end
                  MODE_CLOSED: begin
                     if (!c_sw) mode_in = MODE_FLOATING;
                  end
                  default: begin
                     if (o_sw)      mode_in = MODE_OPENED;
                     else if (c_sw) mode_in = MODE_CLOSED;
                  end
               endcase
            end
         end
         CMD_OPEN: begin
            if (mode_ff != MODE_OPENED && mode_ff != MODE_OPENING) begin
               mode_in   = MODE_OPENING;
               pct_in    = FULL_OPEN;
               moving_in = 1'b1;
               start_in  = req.now_ms;
               wr        = 1'b1;
               sp        = FULL_OPEN;
            end
         end
         CMD_CLOSE: begin
            if (mode_ff != MODE_CLOSED && mode_ff != MODE_CLOSING) begin
               mode_in   = MODE_CLOSING;
               pct_in    = '0;
               moving_in = 1'b1;
               start_in  = req.now_ms;
               wr        = 1'b1;
               sp        = '0;
            end
         end
         default: begin
            pct_in    = clamp_pct;
            mode_in   = MODE_FLOATING;
            moving_in = 1'b0;
            wr        = 1'b1;
            sp        = clamp_pct;
         end
      endcase

      rsp.valve_state       = mode_in;
      rsp.commanded_percent = pct_in;
      rsp.servo_write       = wr;
      rsp.servo_percent     = sp;
      rsp.moving            = moving_in;
      rsp.open_level        = open_seen_in;
      rsp.close_level       = close_seen_in;
      rsp.fault_both        = both_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_UNKNOWN;
         pct_ff        <= '0;
         moving_ff     <= 1'b0;
         open_seen_ff  <= 1'b0;
         close_seen_ff <= 1'b0;
         both_ff       <= 1'b0;
         start_ff      <= '0;
      end else if (step) begin
         mode_ff       <= mode_in;
         pct_ff        <= pct_in;
         moving_ff     <= moving_in;
         open_seen_ff  <= open_seen_in;
         close_seen_ff <= close_seen_in;
         both_ff       <= both_in;
         start_ff      <= start_in;
      end
   end

   a_moving_mode: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (mode_ff == MODE_OPENING || mode_ff == MODE_CLOSING))
      else $error("movement flag set outside opening or closing");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      pct_ff <= FULL_OPEN)
      else $error("commanded percent above full open");

   a_fault_mode: assert property (@(posedge clock) disable iff (reset)
      (step && req.cmd == CMD_TICK && both_in) |=> (mode_ff == MODE_FAULTED))
      else $error("both-switch fault did not fault the valve");

endmodule

`default_nettype wire

// ===== hw/rtl/limit_switch_valve_controller_unit.sv =====
// Limit-switch ball valve controller, top level.
// A request passes the input register and then the result register before its result is valid.
// Throughput: one item per cycle while rsp_stall is low; the state update is a single pass per item.
// Reset (synchronous, active high): mode unknown, status cleared, timeout 5000 ms.
// Depends on lsvc_pkg, lsvc_csr, lsvc_engine.
`default_nettype none

module limit_switch_valve_controller_unit
   import lsvc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;
   logic    out_free;
   logic    step;
   cfg_type cfg;
   rsp_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   lsvc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lsvc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_item_ff),
      .cfg   (cfg),
      .rsp   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   a_servo_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_item_ff.servo_write) |-> (out_item_ff.servo_percent == '0))
      else $error("servo percent set without servo write");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input stage lost an item under backpressure");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_item_ff)))
      else $error("result register changed while stalled");

endmodule

`default_nettype wire

// ===== bench/tb_limit_switch_valve_controller_unit.sv =====
// Testbench for limit_switch_valve_controller_unit: directed and random valve commands,
// checked per transfer against an in-bench valve state predictor with random idling.
// Depends on lsvc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_limit_switch_valve_controller_unit;
   import lsvc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   limit_switch_valve_controller_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // predicted valve state and register copies
   logic              cfg_absent = 1'b0;
   logic [TIME_W-1:0] cfg_timeout = TIMEOUT_RESET_MS;
   logic [MODE_W-1:0] v_mode = MODE_UNKNOWN;
   logic [PCT_W-1:0]  v_pct = '0;
   logic              v_moving = 1'b0;
   logic              v_open_seen = 1'b0;
   logic              v_close_seen = 1'b0;
   logic              v_fault = 1'b0;
   logic [TIME_W-1:0] v_start = '0;

   req_type command_q[$];
   rsp_type status_q[$];
   int failures = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   bit req_sent = 1'b0;
   logic [TIME_W-1:0] gen_ms = '0;
   int gen_dir = 0;
   bit gen_at_limit = 1'b0;

   function automatic rsp_type step_valve(input req_type r);
      rsp_type s;
      logic [CMD_W-1:0] op;
      logic [REQ_PCT_W-1:0] pct_in;
      logic [TIME_W-1:0] elapsed;
      logic o, c, timed_out, wr;
      logic [PCT_W-1:0] sp;
      op = r.cmd;
      pct_in = r.percent_request;
      wr = 1'b0;
      sp = '0;
      if (op == CMD_OPEN && cfg_absent) begin
         op = CMD_SET;
         pct_in = FULL_OPEN_REQ;
      end
      case (op)
         CMD_TICK: begin
            o = r.open_switch && !cfg_absent;
            c = r.close_switch;
            elapsed = r.now_ms - v_start;
            timed_out = elapsed >= cfg_timeout;
            v_open_seen = o;
            v_close_seen = c;
            if (o && c) begin
               v_fault = 1'b1;
               v_moving = 1'b0;
               v_mode = MODE_FAULTED;
            end else begin
               v_fault = 1'b0;
               case (v_mode)
                  MODE_OPENING: begin
                     if (o) begin
                        v_mode = MODE_OPENED;
                        v_moving = 1'b0;
                     end else if (timed_out) begin
                        v_mode = MODE_FAULTED;
                        v_moving = 1'b0;
                     end
                  end
                  MODE_CLOSING: begin
                     if (c) begin
                        v_mode = MODE_CLOSED;
                        v_moving = 1'b0;
                     end else if (timed_out) begin
                        v_mode = MODE_FAULTED;
                        v_moving = 1'b0;
                     end
                  end
                  MODE_OPENED: begin
                     if (!o) v_mode = MODE_FLOATING;
                  end
                  MODE_CLOSED: begin
                     if (!c) v_mode = MODE_FLOATING;
                  end
                  default: begin
                     if (o) v_mode = MODE_OPENED;
                     else if (c) v_mode = MODE_CLOSED;
                  end
               endcase
            end
         end
         CMD_OPEN: begin
            if (v_mode != MODE_OPENED && v_mode != MODE_OPENING) begin
               v_mode = MODE_OPENING;
               v_pct = FULL_OPEN;
               v_moving = 1'b1;
               v_start = r.now_ms;
               wr = 1'b1;
               sp = FULL_OPEN;
            end
         end
         CMD_CLOSE: begin
            if (v_mode != MODE_CLOSED && v_mode != MODE_CLOSING) begin
               v_mode = MODE_CLOSING;
               v_pct = '0;
               v_moving = 1'b1;
               v_start = r.now_ms;
               wr = 1'b1;
               sp = '0;
            end
         end
         default: begin
            v_pct = (pct_in > FULL_OPEN_REQ) ? FULL_OPEN : pct_in[PCT_W-1:0];
            v_mode = MODE_FLOATING;
            v_moving = 1'b0;
            wr = 1'b1;
            sp = v_pct;
         end
      endcase
      s.valve_state = v_mode;
      s.commanded_percent = v_pct;
      s.servo_write = wr;
      s.servo_percent = sp;
      s.moving = v_moving;
      s.open_level = v_open_seen;
      s.close_level = v_close_seen;
      s.fault_both = v_fault;
      return s;
   endfunction

   // command transfer: predict at the accepting edge
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         status_q.push_back(step_valve(req_payload));
         req_sent = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!req_valid || req_sent) begin
         if (!reset && command_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= command_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_sent = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_q.size() == 0) begin
            $error("unexpected status transfer %h", rsp_payload);
            failures++;
         end else begin
            exp_s = status_q.pop_front();
            if (rsp_payload.valve_state !== exp_s.valve_state) begin
               $error("valve_state: expected %0d, got %0d",
                      exp_s.valve_state, rsp_payload.valve_state);
               failures++;
            end
            if (rsp_payload.commanded_percent !== exp_s.commanded_percent) begin
               $error("commanded_percent: expected %0d, got %0d",
                      exp_s.commanded_percent, rsp_payload.commanded_percent);
               failures++;
            end
            if (rsp_payload.servo_write !== exp_s.servo_write) begin
               $error("servo_write: expected %0d, got %0d",
                      exp_s.servo_write, rsp_payload.servo_write);
               failures++;
            end
            if (rsp_payload.servo_percent !== exp_s.servo_percent) begin
               $error("servo_percent: expected %0d, got %0d",
                      exp_s.servo_percent, rsp_payload.servo_percent);
               failures++;
            end
            if (rsp_payload.moving !== exp_s.moving) begin
               $error("moving: expected %0d, got %0d",
                      exp_s.moving, rsp_payload.moving);
               failures++;
            end
            if (rsp_payload.open_level !== exp_s.open_level) begin
               $error("open_level: expected %0d, got %0d",
                      exp_s.open_level, rsp_payload.open_level);
               failures++;
            end
            if (rsp_payload.close_level !== exp_s.close_level) begin
               $error("close_level: expected %0d, got %0d",
                      exp_s.close_level, rsp_payload.close_level);
               failures++;
            end
            if (rsp_payload.fault_both !== exp_s.fault_both) begin
               $error("fault_both: expected %0d, got %0d",
                      exp_s.fault_both, rsp_payload.fault_both);
               failures++;
            end
         end
      end
   end

   task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [TIME_W-1:0] now,
                           input logic o, input logic c, input logic [REQ_PCT_W-1:0] pct);
      req_type r;
      r.cmd = op;
      r.now_ms = now;
      r.open_switch = o;
      r.close_switch = c;
      r.percent_request = pct;
      command_q.push_back(r);
   endtask

   // movement sequences: a command, then ticks that may reach the limit, drift or time out
   task automatic add_random(input int count);
      req_type r;
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if ($urandom_range(19) == 0) gen_ms = $urandom;
         else gen_ms = gen_ms + $urandom_range(40);
         r.now_ms = gen_ms;
         r.percent_request = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(100));
         r.open_switch = 1'($urandom_range(1));
         r.close_switch = 1'($urandom_range(1));
         if (roll < 12) begin
            r.cmd = CMD_OPEN;
            gen_dir = 1;
            gen_at_limit = 1'b0;
         end else if (roll < 24) begin
            r.cmd = CMD_CLOSE;
            gen_dir = 2;
            gen_at_limit = 1'b0;
         end else if (roll < 32) begin
            r.cmd = CMD_SET;
            gen_dir = $urandom_range(2);
            gen_at_limit = 1'b0;
         end else begin
            r.cmd = CMD_TICK;
            roll = $urandom_range(99);
            if (roll < 28) gen_at_limit = 1'b1;
            else if (roll < 34) gen_at_limit = 1'b0;
            if (roll >= 90) begin
               r.open_switch = (roll >= 96) ? 1'b1 : 1'($urandom_range(1));
               r.close_switch = (roll >= 96) ? 1'b1 : 1'($urandom_range(1));
            end else begin
               r.open_switch = gen_at_limit && gen_dir == 1;
               r.close_switch = gen_at_limit && gen_dir == 2;
            end
         end
         command_q.push_back(r);
      end
   endtask

   task automatic wait_drained;
      while (command_q.size() > 0 || req_valid || status_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_OPEN_SWITCH_ABSENT) cfg_absent = data[0];
      else cfg_timeout = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 32;
      rcv_stall_pct = 58;
      csr_write(CSR_OPEN_SWITCH_ABSENT, 32'd0);
      csr_write(CSR_TRANSIT_TIMEOUT_MS, 32'd5000);

      push_cmd(CMD_TICK, 32'd0, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_SET, 32'd1, 1'b0, 1'b0, 8'hFF);
      push_cmd(CMD_OPEN, 32'd10, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_OPEN, 32'd11, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd20, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd30, 1'b1, 1'b0, 8'd0);
      push_cmd(CMD_OPEN, 32'd31, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd40, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_CLOSE, 32'd100, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_CLOSE, 32'd101, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd5100, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd5101, 1'b1, 1'b1, 8'd0);
      push_cmd(CMD_TICK, 32'd5102, 1'b1, 1'b0, 8'd0);
      push_cmd(CMD_SET, 32'd5103, 1'b1, 1'b1, 8'd101);
      push_cmd(CMD_TICK, 32'd5104, 1'b0, 1'b1, 8'd0);
      push_cmd(CMD_CLOSE, 32'd5105, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd5106, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_CLOSE, 32'hFFFF_FF00, 1'b1, 1'b1, 8'hFF);
      push_cmd(CMD_TICK, 32'h0000_0100, 1'b0, 1'b1, 8'd0);
      push_cmd(CMD_OPEN, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'h0000_1386, 1'b1, 1'b0, 8'd0);
      push_cmd(CMD_SET, 32'h0000_1387, 1'b0, 1'b0, 8'd0);
      wait_drained();

      // open switch ignored, zero timeout
      csr_write(CSR_OPEN_SWITCH_ABSENT, 32'd1);
      csr_write(CSR_TRANSIT_TIMEOUT_MS, 32'd0);
      push_cmd(CMD_OPEN, 32'd0, 1'b1, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd1, 1'b1, 1'b0, 8'd0);
      push_cmd(CMD_CLOSE, 32'd2, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd2, 1'b1, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd3, 1'b1, 1'b1, 8'd0);
      wait_drained();

      csr_write(CSR_OPEN_SWITCH_ABSENT, 32'd0);
      csr_write(CSR_TRANSIT_TIMEOUT_MS, 32'hFFFF_FFFF);
      push_cmd(CMD_OPEN, 32'd1, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0);
      push_cmd(CMD_TICK, 32'd0, 1'b0, 1'b0, 8'd0);
      wait_drained();

      csr_write(CSR_TRANSIT_TIMEOUT_MS, 32'd50);
      add_random(500);
      wait_drained();

      send_idle_pct = 58;
      rcv_stall_pct = 32;
      csr_write(CSR_OPEN_SWITCH_ABSENT, 32'd1);
      csr_write(CSR_TRANSIT_TIMEOUT_MS, 32'd200);
      add_random(500);
      wait_drained();

      // no idling; the receiver holds off long enough to back up the input
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      csr_write(CSR_OPEN_SWITCH_ABSENT, 32'd0);
      csr_write(CSR_TRANSIT_TIMEOUT_MS, 32'd20);
      hold_requests++;
      add_random(500);
      wait_drained();

      repeat (10) @(posedge clock);
      if (status_q.size() != 0) failures++;
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== limit_switch_valve_controller_unit.f =====
hw/rtl/lsvc_pkg.sv
hw/rtl/lsvc_csr.sv
hw/rtl/lsvc_engine.sv
hw/rtl/limit_switch_valve_controller_unit.sv
bench/tb_limit_switch_valve_controller_unit.sv
